// ===== rtl/core/color_nearest_palette_classifier_defines.svh =====
// Assertion macros shared by the color classifier RTL.
`ifndef COLOR_NEAREST_PALETTE_CLASSIFIER_DEFINES_SVH
`define COLOR_NEAREST_PALETTE_CLASSIFIER_DEFINES_SVH

// Same-cycle implication, clocked on clock, off during reset
`define CNPC_ASSERT_IMPLIES(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, clocked on clock, off during reset
`define CNPC_ASSERT_NEXT(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/core/cnpc_pkg.sv =====
// Types and constants of the nearest-palette color classifier.
package cnpc_pkg;

   // Field widths
   localparam int INTEN_WIDTH   = 8;
   localparam int LABEL_WIDTH   = 3;
   localparam int DIST_WIDTH    = 18;
   localparam int CONF_WIDTH    = 17;
   localparam int SQ_WIDTH      = 2 * INTEN_WIDTH;
   localparam int PROD_WIDTH    = DIST_WIDTH + CONF_WIDTH;
   localparam int CSR_IDX_WIDTH = 3;
   localparam int NUM_CHAN      = 3;
   localparam int NUM_PAL       = 5;

   // Register indexes on the CSR port
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_RED_WHITE   = 3'd0;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_RED_BLACK   = 3'd1;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_GREEN_WHITE = 3'd2;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_GREEN_BLACK = 3'd3;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_BLUE_WHITE  = 3'd4;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_BLUE_BLACK  = 3'd5;

   // Calibration defaults after reset
   localparam int RED_WHITE_RESET   = 10;
   localparam int RED_BLACK_RESET   = 17;
   localparam int GREEN_WHITE_RESET = 13;
   localparam int GREEN_BLACK_RESET = 32;
   localparam int BLUE_WHITE_RESET  = 12;
   localparam int BLUE_BLACK_RESET  = 30;

   // Result labels
   localparam logic [LABEL_WIDTH-1:0] LABEL_NONE  = 3'd0;
   localparam logic [LABEL_WIDTH-1:0] LABEL_RED   = 3'd1;
   localparam logic [LABEL_WIDTH-1:0] LABEL_GREEN = 3'd2;
   localparam logic [LABEL_WIDTH-1:0] LABEL_BLUE  = 3'd3;
   localparam logic [LABEL_WIDTH-1:0] LABEL_WHITE = 3'd4;
   localparam logic [LABEL_WIDTH-1:0] LABEL_BLACK = 3'd5;

   localparam logic [LABEL_WIDTH-1:0] PAL_LABEL [NUM_PAL] =
      '{LABEL_RED, LABEL_GREEN, LABEL_BLUE, LABEL_WHITE, LABEL_BLACK};

   // Palette colors, (r, g, b) per entry
   localparam logic [INTEN_WIDTH-1:0] PALETTE [NUM_PAL][NUM_CHAN] = '{
      '{8'd255, 8'd161, 8'd170},
      '{8'd182, 8'd174, 8'd127},
      '{8'd255, 8'd174, 8'd212},
      '{8'd255, 8'd255, 8'd255},
      '{8'd0,   8'd0,   8'd0}
   };

   localparam logic [INTEN_WIDTH-1:0] INTEN_MAX = 8'd255;

   // Distance scale: 3 * 255^2
   localparam logic [DIST_WIDTH-1:0] FAR_DIST = 18'd195075;

   // Confidence = floor(x * 2^16 / FAR_DIST) via reciprocal floor(2^34 / FAR_DIST)
   localparam int                    CONF_FRAC  = 16;
   localparam int                    CONF_SHIFT = 18;
   localparam logic [CONF_WIDTH-1:0] CONF_RECIP = 17'd88068;
   localparam logic [CONF_WIDTH-1:0] CONF_FULL  = 17'd65536;

   // How a channel's intensity is formed
   typedef enum logic [1:0] {
      MODE_FULL,
      MODE_ZERO,
      MODE_DIV
   } inten_mode_type;

endpackage

// ===== rtl/core/cnpc_if.sv =====
// Valid/ready channel interfaces of the color classifier.

// Raw count readings
interface cnpc_req_if #(parameter int COUNT_WIDTH = 20);
   logic                   valid;
   logic                   ready;
   logic [COUNT_WIDTH-1:0] red_raw;
   logic [COUNT_WIDTH-1:0] green_raw;
   logic [COUNT_WIDTH-1:0] blue_raw;

   modport source (output valid, output red_raw, output green_raw, output blue_raw,
                   input ready);
   modport sink   (input valid, input red_raw, input green_raw, input blue_raw,
                   output ready);
endinterface

// Classification results
interface cnpc_rsp_if;
   import cnpc_pkg::*;
   logic                   valid;
   logic                   ready;
   logic [LABEL_WIDTH-1:0] color_label;
   logic [DIST_WIDTH-1:0]  nearest_distance;
   logic [CONF_WIDTH-1:0]  confidence_q16;

   modport source (output valid, output color_label, output nearest_distance,
                   output confidence_q16, input ready);
   modport sink   (input valid, input color_label, input nearest_distance,
                   input confidence_q16, output ready);
endinterface

// Calibration register writes
interface cnpc_csr_if #(parameter int COUNT_WIDTH = 20);
   import cnpc_pkg::*;
   logic                     valid;
   logic                     ready;
   logic [CSR_IDX_WIDTH-1:0] index;
   logic [COUNT_WIDTH-1:0]   data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/core/color_nearest_palette_classifier.sv =====
// Top level of the nearest-palette color classifier pipeline.
//
//  channel   dir   transaction
//  req_bus   in    red_raw, green_raw, blue_raw raw pulse counts
//  rsp_bus   out   color_label, nearest_distance, confidence_q16
//  csr_bus   in    index, data: white/black calibration counts
//
// One transaction per cycle while rsp_bus is ready; the pipeline has the eight
// restoring-division stages (one quotient bit per stage) plus seven others.
// Reset (synchronous) empties the pipeline and loads the default calibration.
// A stall on rsp_bus holds only the full stages; empty stages keep filling.
// csr_bus is always ready; writes take effect at once.
`include "color_nearest_palette_classifier_defines.svh"

module color_nearest_palette_classifier #(
   parameter int COUNT_WIDTH = 20
) (
   input  logic        clock,
   input  logic        reset,
   cnpc_req_if.sink    req_bus,
   cnpc_rsp_if.source  rsp_bus,
   cnpc_csr_if.sink    csr_bus
);
   import cnpc_pkg::*;

   localparam int REM_WIDTH  = COUNT_WIDTH + INTEN_WIDTH;
   localparam int NUM_DIV    = INTEN_WIDTH;
   localparam int ST_IN      = 0;
   localparam int ST_SQ      = NUM_DIV + 1;
   localparam int ST_SUM     = NUM_DIV + 2;
   localparam int ST_MIN     = NUM_DIV + 3;
   localparam int ST_RCP     = NUM_DIV + 4;
   localparam int ST_BACK    = NUM_DIV + 5;
   localparam int ST_OUT     = NUM_DIV + 6;
   localparam int NUM_STAGES = ST_OUT + 1;

   // Calibration registers
   logic [COUNT_WIDTH-1:0] white_ff [NUM_CHAN];
   logic [COUNT_WIDTH-1:0] black_ff [NUM_CHAN];

   // Pipeline control
   logic [NUM_STAGES-1:0] vld_ff;
   logic [NUM_STAGES-1:0] vld_in;
   logic [NUM_STAGES:0]   adv;

   // Input and division stages
   logic [COUNT_WIDTH-1:0] raw       [NUM_CHAN];
   logic [REM_WIDTH-1:0]   rem_ff    [NUM_DIV+1][NUM_CHAN];
   logic [REM_WIDTH-1:0]   rem_in    [NUM_DIV+1][NUM_CHAN];
   logic [COUNT_WIDTH-1:0] den_ff    [NUM_DIV+1][NUM_CHAN];
   logic [COUNT_WIDTH-1:0] den_in    [NUM_DIV+1][NUM_CHAN];
   logic [INTEN_WIDTH-1:0] quo_ff    [NUM_DIV+1][NUM_CHAN];
   logic [INTEN_WIDTH-1:0] quo_in    [NUM_DIV+1][NUM_CHAN];
   inten_mode_type         mode_ff   [NUM_DIV+1][NUM_CHAN];
   inten_mode_type         mode_in   [NUM_DIV+1][NUM_CHAN];
   logic [NUM_DIV:0]       dzero_ff;
   logic [NUM_DIV:0]       dzero_in;

   // Distance stages
   logic [INTEN_WIDTH-1:0] inten     [NUM_CHAN];
   logic [SQ_WIDTH-1:0]    sq_ff     [NUM_PAL][NUM_CHAN];
   logic [SQ_WIDTH-1:0]    sq_in     [NUM_PAL][NUM_CHAN];
   logic                   sq_zero_ff;
   logic [DIST_WIDTH-1:0]  sum_ff    [NUM_PAL];
   logic [DIST_WIDTH-1:0]  sum_in    [NUM_PAL];
   logic                   sum_zero_ff;
   logic [LABEL_WIDTH-1:0] min_lab_ff, min_lab_in;
   logic [DIST_WIDTH-1:0]  min_dist_ff, min_dist_in;

   // Confidence stages
   logic [DIST_WIDTH-1:0]  rcp_x;
   logic [PROD_WIDTH-1:0]  rcp_prod;
   logic [CONF_WIDTH-1:0]  rcp_q_ff, rcp_q_in;
   logic [DIST_WIDTH-1:0]  rcp_x_ff;
   logic [LABEL_WIDTH-1:0] rcp_lab_ff;
   logic [DIST_WIDTH-1:0]  rcp_dist_ff;
   logic [PROD_WIDTH-1:0]  back_ff, back_in;
   logic [PROD_WIDTH-1:0]  xs_ff, xs_in;
   logic [CONF_WIDTH-1:0]  back_q_ff;
   logic [LABEL_WIDTH-1:0] back_lab_ff;
   logic [DIST_WIDTH-1:0]  back_dist_ff;
   logic [PROD_WIDTH-1:0]  corr_rem;
   logic [CONF_WIDTH-1:0]  out_conf_in;
   logic [LABEL_WIDTH-1:0] out_lab_ff;
   logic [DIST_WIDTH-1:0]  out_dist_ff;
   logic [CONF_WIDTH-1:0]  out_conf_ff;

   // ---------------------------------------------------------------- CSR
   assign csr_bus.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         white_ff[0] <= COUNT_WIDTH'(RED_WHITE_RESET);
         black_ff[0] <= COUNT_WIDTH'(RED_BLACK_RESET);
         white_ff[1] <= COUNT_WIDTH'(GREEN_WHITE_RESET);
         black_ff[1] <= COUNT_WIDTH'(GREEN_BLACK_RESET);
         white_ff[2] <= COUNT_WIDTH'(BLUE_WHITE_RESET);
         black_ff[2] <= COUNT_WIDTH'(BLUE_BLACK_RESET);
      end else if (csr_bus.valid) begin
         case (csr_bus.index)
            CSR_RED_WHITE:   white_ff[0] <= csr_bus.data;
            CSR_RED_BLACK:   black_ff[0] <= csr_bus.data;
            CSR_GREEN_WHITE: white_ff[1] <= csr_bus.data;
            CSR_GREEN_BLACK: black_ff[1] <= csr_bus.data;
            CSR_BLUE_WHITE:  white_ff[2] <= csr_bus.data;
            CSR_BLUE_BLACK:  black_ff[2] <= csr_bus.data;
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------- pipeline control
   // A stage loads when it is empty or its contents move on
   always_comb begin
      adv[NUM_STAGES] = rsp_bus.ready;
      for (int k = NUM_STAGES - 1; k >= 0; k--) begin
         adv[k] = !vld_ff[k] || adv[k+1];
      end
      vld_in[ST_IN] = req_bus.valid;
      for (int k = 1; k < NUM_STAGES; k++) begin
         vld_in[k] = vld_ff[k-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         for (int k = 0; k < NUM_STAGES; k++) begin
            if (adv[k]) begin
               vld_ff[k] <= vld_in[k];
            end
         end
      end
   end

   assign req_bus.ready = adv[ST_IN];

   // ------------------------------------------------ input and division
   assign raw[0] = req_bus.red_raw;
   assign raw[1] = req_bus.green_raw;
   assign raw[2] = req_bus.blue_raw;

   always_comb begin
      logic [COUNT_WIDTH-1:0] num;
      logic [REM_WIDTH-1:0]   trial;
      logic                   ge;
      // Input stage: pick branch, numerator (black-raw)*255, divisor black-white
      dzero_in[ST_IN] = (raw[0] == '0) && (raw[1] == '0) && (raw[2] == '0);
      for (int c = 0; c < NUM_CHAN; c++) begin
         num = black_ff[c] - raw[c];
         if (raw[c] <= white_ff[c]) begin
            mode_in[0][c] = MODE_FULL;
         end else if (raw[c] >= black_ff[c]) begin
            mode_in[0][c] = MODE_ZERO;
         end else begin
            mode_in[0][c] = MODE_DIV;
         end
         rem_in[0][c] = (REM_WIDTH'(num) << INTEN_WIDTH) - REM_WIDTH'(num);
         den_in[0][c] = black_ff[c] - white_ff[c];
         quo_in[0][c] = '0;
      end
      // Restoring division, one quotient bit per stage, MSB first
      for (int s = 1; s <= NUM_DIV; s++) begin
         dzero_in[s] = dzero_ff[s-1];
         for (int c = 0; c < NUM_CHAN; c++) begin
            trial = REM_WIDTH'(den_ff[s-1][c]) << (NUM_DIV - s);
            ge    = rem_ff[s-1][c] >= trial;
            rem_in[s][c]  = ge ? (rem_ff[s-1][c] - trial) : rem_ff[s-1][c];
            quo_in[s][c]  = quo_ff[s-1][c];
            quo_in[s][c][NUM_DIV - s] = ge;
            den_in[s][c]  = den_ff[s-1][c];
            mode_in[s][c] = mode_ff[s-1][c];
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int s = 0; s <= NUM_DIV; s++) begin
         if (adv[s]) begin
            dzero_ff[s] <= dzero_in[s];
            for (int c = 0; c < NUM_CHAN; c++) begin
               rem_ff[s][c]  <= rem_in[s][c];
               den_ff[s][c]  <= den_in[s][c];
               quo_ff[s][c]  <= quo_in[s][c];
               mode_ff[s][c] <= mode_in[s][c];
            end
         end
      end
   end

   // ------------------------------------------------ squared differences
   always_comb begin
      logic [INTEN_WIDTH-1:0] diff;
      for (int c = 0; c < NUM_CHAN; c++) begin
         case (mode_ff[NUM_DIV][c])
            MODE_FULL: inten[c] = INTEN_MAX;
            MODE_ZERO: inten[c] = '0;
            default:   inten[c] = quo_ff[NUM_DIV][c];
         endcase
      end
      for (int p = 0; p < NUM_PAL; p++) begin
         for (int c = 0; c < NUM_CHAN; c++) begin
            diff = (inten[c] >= PALETTE[p][c]) ? (inten[c] - PALETTE[p][c])
                                               : (PALETTE[p][c] - inten[c]);
            sq_in[p][c] = SQ_WIDTH'(diff) * SQ_WIDTH'(diff);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv[ST_SQ]) begin
         sq_ff      <= sq_in;
         sq_zero_ff <= dzero_ff[NUM_DIV];
      end
   end

   // ------------------------------------------------ distance sums
   always_comb begin
      for (int p = 0; p < NUM_PAL; p++) begin
         sum_in[p] = DIST_WIDTH'(sq_ff[p][0]) + DIST_WIDTH'(sq_ff[p][1])
                   + DIST_WIDTH'(sq_ff[p][2]);
      end
   end

   always_ff @(posedge clock) begin
      if (adv[ST_SUM]) begin
         sum_ff      <= sum_in;
         sum_zero_ff <= sq_zero_ff;
      end
   end

   // ------------------------------------------------ nearest entry, first wins ties
   always_comb begin
      min_lab_in  = PAL_LABEL[0];
      min_dist_in = sum_ff[0];
      for (int p = 1; p < NUM_PAL; p++) begin
         if (sum_ff[p] < min_dist_in) begin
            min_lab_in  = PAL_LABEL[p];
            min_dist_in = sum_ff[p];
         end
      end
      // All-zero reading: no label, full distance
      if (sum_zero_ff) begin
         min_lab_in  = LABEL_NONE;
         min_dist_in = FAR_DIST;
      end
   end

   always_ff @(posedge clock) begin
      if (adv[ST_MIN]) begin
         min_lab_ff  <= min_lab_in;
         min_dist_ff <= min_dist_in;
      end
   end

   // ------------------------------------------------ confidence estimate
   // q0 = floor(x * recip / 2^18) is exact or one short
   assign rcp_x    = FAR_DIST - min_dist_ff;
   assign rcp_prod = PROD_WIDTH'(rcp_x) * PROD_WIDTH'(CONF_RECIP);
   assign rcp_q_in = rcp_prod[CONF_SHIFT +: CONF_WIDTH];

   always_ff @(posedge clock) begin
      if (adv[ST_RCP]) begin
         rcp_q_ff    <= rcp_q_in;
         rcp_x_ff    <= rcp_x;
         rcp_lab_ff  <= min_lab_ff;
         rcp_dist_ff <= min_dist_ff;
      end
   end

   // Back-multiply the estimate for the correction step
   assign back_in = PROD_WIDTH'(rcp_q_ff) * PROD_WIDTH'(FAR_DIST);
   assign xs_in   = PROD_WIDTH'(rcp_x_ff) << CONF_FRAC;

   always_ff @(posedge clock) begin
      if (adv[ST_BACK]) begin
         back_ff      <= back_in;
         xs_ff        <= xs_in;
         back_q_ff    <= rcp_q_ff;
         back_lab_ff  <= rcp_lab_ff;
         back_dist_ff <= rcp_dist_ff;
      end
   end

   // ------------------------------------------------ correction and output register
   assign corr_rem    = xs_ff - back_ff;
   assign out_conf_in = back_q_ff + CONF_WIDTH'(corr_rem >= PROD_WIDTH'(FAR_DIST));

   always_ff @(posedge clock) begin
      if (adv[ST_OUT]) begin
         out_lab_ff  <= back_lab_ff;
         out_dist_ff <= back_dist_ff;
         out_conf_ff <= out_conf_in;
      end
   end

   assign rsp_bus.valid            = vld_ff[ST_OUT];
   assign rsp_bus.color_label      = out_lab_ff;
   assign rsp_bus.nearest_distance = out_dist_ff;
   assign rsp_bus.confidence_q16   = out_conf_ff;

   // ------------------------------------------------ assertions
   `CNPC_ASSERT_NEXT(a_accept_fills_input, req_bus.valid && req_bus.ready, vld_ff[ST_IN], "accepted transaction did not enter the input stage")
   `CNPC_ASSERT_IMPLIES(a_div_remainder, vld_ff[NUM_DIV], (mode_ff[NUM_DIV][0] != MODE_DIV || rem_ff[NUM_DIV][0] < REM_WIDTH'(den_ff[NUM_DIV][0])) && (mode_ff[NUM_DIV][1] != MODE_DIV || rem_ff[NUM_DIV][1] < REM_WIDTH'(den_ff[NUM_DIV][1])) && (mode_ff[NUM_DIV][2] != MODE_DIV || rem_ff[NUM_DIV][2] < REM_WIDTH'(den_ff[NUM_DIV][2])), "division remainder not below divisor")
   `CNPC_ASSERT_IMPLIES(a_recip_bound, vld_ff[ST_BACK], back_ff <= xs_ff && (xs_ff - back_ff) < (PROD_WIDTH'(FAR_DIST) << 1), "reciprocal estimate off by more than one")
   `CNPC_ASSERT_IMPLIES(a_none_result, rsp_bus.valid && rsp_bus.color_label == LABEL_NONE, rsp_bus.nearest_distance == FAR_DIST && rsp_bus.confidence_q16 == '0, "none label with wrong distance or confidence")
   `CNPC_ASSERT_IMPLIES(a_full_conf, rsp_bus.valid, (rsp_bus.confidence_q16 == CONF_FULL) == (rsp_bus.nearest_distance == '0), "full confidence does not match zero distance")

endmodule
